### rtl/cdd_pkg.sv
// Shared types, constants and month tables for the calendar date difference block.
package cdd_pkg;

   localparam int YEAR_W   = 14;
   localparam int MONTH_W  = 4;
   localparam int DAY_W    = 5;
   localparam int COUNT_W  = 22;
   localparam int DAYNUM_W = 23;   // absolute day number, holds 365 * 16383 plus margin
   localparam int QUOT_W   = 8;    // year / 100 for any 14-bit year
   localparam int LEAPS_W  = 13;
   localparam int DBM_W    = 9;

   localparam logic [YEAR_W-1:0] YEAR_LIMIT = 14'd9999;

   // floor(y / 100) = (y * DIV100_MUL) >> DIV100_SHIFT, exact for y < 2^15
   localparam logic [14:0] DIV100_MUL   = 15'd20972;
   localparam int          DIV100_SHIFT = 21;
   localparam int          PROD_W       = 29;

   localparam logic [DAYNUM_W-1:0] DAYS_PER_YEAR = 23'd365;

   // Per-stage load enables of the date pipeline.
   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
   } cdd_stage_en_type;

   // Days in the months before month m, common year.
   function automatic logic [DBM_W-1:0] days_before(input logic [MONTH_W-1:0] m);
      logic [DBM_W-1:0] r;
      case (m)
         4'd2:    r = 9'd31;
         4'd3:    r = 9'd59;
         4'd4:    r = 9'd90;
         4'd5:    r = 9'd120;
         4'd6:    r = 9'd151;
         4'd7:    r = 9'd181;
         4'd8:    r = 9'd212;
         4'd9:    r = 9'd243;
         4'd10:   r = 9'd273;
         4'd11:   r = 9'd304;
         4'd12:   r = 9'd334;
         default: r = 9'd0;
      endcase
      return r;
   endfunction

   // Month length in a common year; February handled by the caller.
   function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
      logic [DAY_W-1:0] r;
      case (m)
         4'd2:    r = 5'd28;
         4'd4:    r = 5'd30;
         4'd6:    r = 5'd30;
         4'd9:    r = 5'd30;
         4'd11:   r = 5'd30;
         default: r = 5'd31;
      endcase
      return r;
   endfunction

endpackage

### rtl/cdd_if.sv
// Valid/ready channel interfaces for date pairs and day counts.
interface cdd_req_if import cdd_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [YEAR_W-1:0]  start_year;
   logic [MONTH_W-1:0] start_month;
   logic [DAY_W-1:0]   start_day;
   logic [YEAR_W-1:0]  end_year;
   logic [MONTH_W-1:0] end_month;
   logic [DAY_W-1:0]   end_day;

   modport source (output valid, start_year, start_month, start_day,
                          end_year, end_month, end_day,
                   input  ready);
   modport sink   (input  valid, start_year, start_month, start_day,
                          end_year, end_month, end_day,
                   output ready);
endinterface

interface cdd_rsp_if import cdd_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [COUNT_W-1:0] day_count;
   logic               bad_input;

   modport source (output valid, day_count, bad_input, input ready);
   modport sink   (input  valid, day_count, bad_input, output ready);
endinterface

### rtl/cdd_date_unit.sv
// Three-stage conversion of one date to an absolute day number plus a validity flag.
module cdd_date_unit
   import cdd_pkg::*;
(
   input  logic                clock,
   input  cdd_stage_en_type    en,
   input  logic [YEAR_W-1:0]   year,
   input  logic [MONTH_W-1:0]  month,
   input  logic [DAY_W-1:0]    day,
   output logic [DAYNUM_W-1:0] day_num,
   output logic                date_ok
);

   // stage 1: year / 100 product, month lookups
   logic [PROD_W-1:0]  prod_ff;
   logic [YEAR_W-1:0]  y1_ff;
   logic [DAY_W-1:0]   d1_ff;
   logic [DBM_W-1:0]   dbm1_ff;
   logic [DAY_W-1:0]   len1_ff;
   logic               feb1_ff;
   logic               past_feb1_ff;
   logic               fields_ok1_ff;
   logic               fields_ok1_in;

   assign fields_ok1_in = (year <= YEAR_LIMIT) && (month != 4'd0) && (month <= 4'd12)
                          && (day != 5'd0);

   always_ff @(posedge clock) begin
      if (en.s1) begin
         prod_ff       <= PROD_W'(year) * PROD_W'(DIV100_MUL);
         y1_ff         <= year;
         d1_ff         <= day;
         dbm1_ff       <= days_before(month);
         len1_ff       <= month_len(month);
         feb1_ff       <= (month == 4'd2);
         past_feb1_ff  <= (month > 4'd2);
         fields_ok1_ff <= fields_ok1_in;
      end
   end

   // stage 2: leap test, leap count, day range check
   logic [QUOT_W-1:0]  q;
   logic               rem_nz;
   logic               leap;
   logic [LEAPS_W-1:0] quarter;
   logic [LEAPS_W-1:0] cent;
   logic [LEAPS_W-1:0] quad;
   logic [DAY_W-1:0]   len_eff;

   assign q       = prod_ff[DIV100_SHIFT +: QUOT_W];
   assign rem_nz  = (15'(q) * 15'd100) != {1'b0, y1_ff};
   // divisible by 4, and not a century unless (y / 100) is divisible by 4
   assign leap    = (y1_ff[1:0] == 2'd0) && (rem_nz || (q[1:0] == 2'd0));
   assign quarter = LEAPS_W'((15'(y1_ff) + 15'd3) >> 2);                // ceil(y/4)
   assign cent    = LEAPS_W'(q) + LEAPS_W'(rem_nz);                     // ceil(y/100)
   assign quad    = LEAPS_W'(q >> 2) + LEAPS_W'((q[1:0] != 2'd0) || rem_nz); // ceil(y/400)
   assign len_eff = (feb1_ff && leap) ? 5'd29 : len1_ff;

   logic [YEAR_W-1:0]  y2_ff;
   logic [LEAPS_W-1:0] leaps2_ff;
   logic [DBM_W-1:0]   dbm2_ff;
   logic [DAY_W-1:0]   d2_ff;
   logic               extra2_ff;
   logic               ok2_ff;

   always_ff @(posedge clock) begin
      if (en.s2) begin
         y2_ff     <= y1_ff;
         leaps2_ff <= quarter - cent + quad;
         dbm2_ff   <= dbm1_ff;
         d2_ff     <= d1_ff;
         extra2_ff <= past_feb1_ff && leap;
         ok2_ff    <= fields_ok1_ff && (d1_ff <= len_eff);
      end
   end

   // stage 3: sum into the absolute day number
   logic [DAYNUM_W-1:0] num3_ff;
   logic                ok3_ff;

   always_ff @(posedge clock) begin
      if (en.s3) begin
         num3_ff <= DAYNUM_W'(y2_ff) * DAYS_PER_YEAR + DAYNUM_W'(leaps2_ff)
                    + DAYNUM_W'(dbm2_ff) + DAYNUM_W'(d2_ff) + DAYNUM_W'(extra2_ff);
         ok3_ff  <= ok2_ff;
      end
   end

   assign day_num = num3_ff;
   assign date_ok = ok3_ff;

endmodule

### rtl/calendar_date_difference.sv
// Top level: pipelined Gregorian day count between two dates.
//
// Usage:
//   req  - one beat carries a date pair (start, end) as year, month, day.
//   rsp  - one beat per request: day_count (end minus start, in days) and
//          bad_input, set with day_count zero when a date is malformed
//          (month outside 1..12, day zero or past month end, year above
//          9999) or the end date is before the start date.
// Pipeline: three stages convert each date (year / 100 by reciprocal
//   multiply, leap count, day number sum); the fourth compares and
//   subtracts into the output register.
// Throughput: one beat per cycle while rsp is ready; every stage has its
//   own valid bit and loads whenever it is empty or the stage after it moves.
// Stall: when rsp is held off, stages fill up behind the output register;
//   req.ready drops only once all four are full. Nothing is dropped or
//   repeated.
// Reset: synchronous, clears all valid bits; the pipeline comes up empty.
module calendar_date_difference
   import cdd_pkg::*;
(
   input  logic  clock,
   input  logic  reset,
   cdd_req_if.sink   req,
   cdd_rsp_if.source rsp
);

   // valid bits, one per stage
   logic v1_ff, v2_ff, v3_ff, v4_ff;

   // a stage loads when it is empty or its content moves on
   logic en4;
   cdd_stage_en_type en;

   assign en4   = !v4_ff || rsp.ready;
   assign en.s3 = !v3_ff || en4;
   assign en.s2 = !v2_ff || en.s3;
   assign en.s1 = !v1_ff || en.s2;

   assign req.ready = en.s1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (en.s1) v1_ff <= req.valid;
         if (en.s2) v2_ff <= v1_ff;
         if (en.s3) v3_ff <= v2_ff;
         if (en4)   v4_ff <= v3_ff;
      end
   end

   // both dates go through identical converters in lockstep
   logic [DAYNUM_W-1:0] start_num, end_num;
   logic                start_ok, end_ok;

   cdd_date_unit u_start (
      .clock   (clock),
      .en      (en),
      .year    (req.start_year),
      .month   (req.start_month),
      .day     (req.start_day),
      .day_num (start_num),
      .date_ok (start_ok)
   );

   cdd_date_unit u_end (
      .clock   (clock),
      .en      (en),
      .year    (req.end_year),
      .month   (req.end_month),
      .day     (req.end_day),
      .day_num (end_num),
      .date_ok (end_ok)
   );

   // stage 4: order check and difference into the output register
   logic               good;
   logic [COUNT_W-1:0] count_in;
   logic [COUNT_W-1:0] count_ff;
   logic               bad_ff;

   assign good     = start_ok && end_ok && (end_num >= start_num);
   // difference of valid dates fits 22 bits
   assign count_in = good ? COUNT_W'(end_num - start_num) : '0;

   always_ff @(posedge clock) begin
      if (en4) begin
         count_ff <= count_in;
         bad_ff   <= !good;
      end
   end

   assign rsp.valid     = v4_ff;
   assign rsp.day_count = count_ff;
   assign rsp.bad_input = bad_ff;

endmodule
